/* design/dam_pkg.sv */
package dam_pkg;

    localparam int PADDR_W      = 3;
    localparam int WINDOW_RESET = 8;
    localparam logic REG_WINDOW = 1'b0;

    typedef struct packed {
        logic              action;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] smooth_x;
        logic signed [15:0] smooth_z;
    } out_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQA,
        N_SQB,
        N_ROOT,
        N_LOAD,
        N_DIV
    } norm_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_NORM_IN,
        T_UPDATE,
        T_SHIFT,
        T_NORM_SUM,
        T_OUT
    } top_state_t;

    localparam logic ACT_CLEAR = 1'b1;

endpackage

/* design/dam_ring.sv */
module dam_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/dam_norm.sv */
module dam_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    output logic               done,
    output logic signed [15:0] ox,
    output logic signed [15:0] oz
);

    dam_pkg::norm_state_t state_reg, state_next;

    logic signed [15:0] a_reg, b_reg;
    logic [31:0] sq_reg;
    logic [59:0] src_reg;
    logic [33:0] rem_reg;
    logic [29:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] num_reg;
    logic [30:0] drem_reg;
    logic [15:0] q_reg;
    logic        sel_reg;
    logic        done_reg;
    logic signed [15:0] ox_reg, oz_reg;

    logic signed [15:0] mul_in;
    logic signed [31:0] mul_p;
    logic [33:0] rem_sh, trial;
    logic        root_ge;
    logic signed [15:0] cur;
    logic [15:0] mag;
    logic [43:0] nnum;
    logic [30:0] dt;
    logic        div_ge;
    logic [15:0] q_fin, q_sat;
    logic signed [15:0] res;

    assign mul_in  = (state_reg == dam_pkg::N_SQA) ? a_reg : b_reg;
    assign mul_p   = mul_in * mul_in;
    assign rem_sh  = {rem_reg[31:0], src_reg[59:58]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign root_ge = rem_sh >= trial;
    assign cur     = sel_reg ? b_reg : a_reg;
    assign mag     = cur[15] ? 16'(-cur) : 16'(cur);
    assign nnum    = {mag, 28'b0} + {15'b0, root_reg[29:1]};
    assign dt      = {drem_reg[29:0], num_reg[15]};
    assign div_ge  = dt >= {1'b0, root_reg};
    assign q_fin   = {q_reg[14:0], div_ge};
    assign q_sat   = (q_fin > 16'd16384) ? 16'd16384 : q_fin;
    assign res     = cur[15] ? -$signed(q_sat) : $signed(q_sat);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dam_pkg::N_IDLE:
            begin
                if (start && !(a == 16'sd0 && b == 16'sd0))
                begin
                    state_next = dam_pkg::N_SQA;
                end
            end
            dam_pkg::N_SQA:  state_next = dam_pkg::N_SQB;
            dam_pkg::N_SQB:  state_next = dam_pkg::N_ROOT;
            dam_pkg::N_ROOT:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = dam_pkg::N_LOAD;
                end
            end
            dam_pkg::N_LOAD: state_next = dam_pkg::N_DIV;
            dam_pkg::N_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = sel_reg ? dam_pkg::N_IDLE : dam_pkg::N_LOAD;
                end
            end
            default: state_next = dam_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dam_pkg::N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == dam_pkg::N_IDLE && start && a == 16'sd0 && b == 16'sd0)
                      || (state_reg == dam_pkg::N_DIV && cnt_reg == 5'd0 && sel_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            dam_pkg::N_IDLE:
            begin
                // results hold until the next start
                if (start)
                begin
                    a_reg   <= a;
                    b_reg   <= b;
                    sel_reg <= 1'b0;
                    ox_reg  <= 16'sd0;
                    oz_reg  <= 16'sd0;
                end
            end
            dam_pkg::N_SQA:
            begin
                sq_reg <= 32'(mul_p);
            end
            dam_pkg::N_SQB:
            begin
                src_reg  <= {sq_reg + 32'(mul_p), 28'b0};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'd29;
            end
            dam_pkg::N_ROOT:
            begin
                rem_reg  <= root_ge ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[28:0], root_ge};
                src_reg  <= {src_reg[57:0], 2'b00};
                cnt_reg  <= cnt_reg - 5'd1;
            end
            dam_pkg::N_LOAD:
            begin
                drem_reg <= {3'b000, nnum[43:16]};
                num_reg  <= nnum[15:0];
                q_reg    <= '0;
                cnt_reg  <= 5'd15;
            end
            dam_pkg::N_DIV:
            begin
                drem_reg <= div_ge ? dt - {1'b0, root_reg} : dt;
                num_reg  <= {num_reg[14:0], 1'b0};
                q_reg    <= q_fin;
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    if (sel_reg)
                    begin
                        oz_reg <= res;
                    end
                    else
                    begin
                        ox_reg <= res;
                    end
                    sel_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign ox   = ox_reg;
    assign oz   = oz_reg;

endmodule

/* design/direction_moving_average_top.sv */
// channel | dir  | handshake        | word
// in      | in   | in_valid/ready   | dam_pkg::in_t  (action, dir_x, dir_z)
// out     | out  | out_valid/ready  | dam_pkg::out_t (smooth_x, smooth_z)
// cfg     | in   | APB, pready = 1  | window_size at byte address 0
// An update word runs from accept to in_ready through two normalizations on one
// shared unit (30-step square root, two 16-step divides) plus up to six sum
// shift steps. A zero vector or zero sum skips the arithmetic of its normalization.
// A clear word goes straight to the output state. in_ready is high only when idle.
// A finished word waits in the output register while out_ready is low.
// rst_n clears ring (valid bits), sums, write slot; window_size resets to 8.
module direction_moving_average_top #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  dam_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output dam_pkg::out_t                out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dam_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = 16 + SLOT_W;
    localparam int WIN_RST = (dam_pkg::WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                                  : dam_pkg::WINDOW_RESET;

    dam_pkg::top_state_t state_reg, state_next;

    logic [WIN_W-1:0]        window_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [WINDOW_MAX-1:0]   valid_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_z_reg, sh_x_reg, sh_z_reg;
    logic                    out_valid_reg;
    dam_pkg::out_t           out_reg, res_reg;

    logic                    accept, cfg_wr, fits, norm_start, norm_done;
    logic signed [15:0]      norm_a, norm_b, nx, nz, old_x, old_z;
    logic [31:0]             rdata;
    logic [6:0]              w7;
    logic [WIN_W-1:0]        w_clamp, slot_inc;
    logic signed [SUM_W-1:0] new_x, new_z;

    assign accept = in_valid && in_ready;
    assign cfg_wr = psel && penable && pwrite && paddr[2] == dam_pkg::REG_WINDOW;
    assign w7     = pwdata[6:0];
    assign w_clamp = (w7 == 7'd0) ? WIN_W'(1)
                   : (int'(w7) > WINDOW_MAX) ? WIN_W'(WINDOW_MAX) : WIN_W'(w7);

    assign fits = (&sh_x_reg[SUM_W-1:15] || ~|sh_x_reg[SUM_W-1:15])
               && (&sh_z_reg[SUM_W-1:15] || ~|sh_z_reg[SUM_W-1:15]);

    assign norm_start = (state_reg == dam_pkg::T_IDLE && accept
                         && in_data.action != dam_pkg::ACT_CLEAR)
                     || (state_reg == dam_pkg::T_SHIFT && fits);
    assign norm_a = (state_reg == dam_pkg::T_IDLE) ? in_data.dir_x : 16'(sh_x_reg);
    assign norm_b = (state_reg == dam_pkg::T_IDLE) ? in_data.dir_z : 16'(sh_z_reg);

    dam_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .a     (norm_a),
        .b     (norm_b),
        .done  (norm_done),
        .ox    (nx),
        .oz    (nz)
    );

    dam_ring #(
        .DEPTH (WINDOW_MAX),
        .AW    (SLOT_W)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == dam_pkg::T_UPDATE),
        .waddr (slot_reg),
        .wdata ({nx, nz}),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    assign old_x    = valid_reg[slot_reg] ? rdata[31:16] : 16'sd0;
    assign old_z    = valid_reg[slot_reg] ? rdata[15:0]  : 16'sd0;
    assign new_x    = sum_x_reg + SUM_W'(nx) - SUM_W'(old_x);
    assign new_z    = sum_z_reg + SUM_W'(nz) - SUM_W'(old_z);
    assign slot_inc = WIN_W'(slot_reg) + WIN_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dam_pkg::T_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_data.action == dam_pkg::ACT_CLEAR) ? dam_pkg::T_OUT
                                                                        : dam_pkg::T_NORM_IN;
                end
            end
            dam_pkg::T_NORM_IN:
            begin
                if (norm_done)
                begin
                    state_next = dam_pkg::T_UPDATE;
                end
            end
            dam_pkg::T_UPDATE: state_next = dam_pkg::T_SHIFT;
            dam_pkg::T_SHIFT:
            begin
                if (fits)
                begin
                    state_next = dam_pkg::T_NORM_SUM;
                end
            end
            dam_pkg::T_NORM_SUM:
            begin
                if (norm_done)
                begin
                    state_next = dam_pkg::T_OUT;
                end
            end
            dam_pkg::T_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = dam_pkg::T_IDLE;
                end
            end
            default: state_next = dam_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dam_pkg::T_IDLE;
            window_reg    <= WIN_W'(WIN_RST);
            slot_reg      <= '0;
            valid_reg     <= '0;
            sum_x_reg     <= '0;
            sum_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                window_reg <= w_clamp;
                slot_reg   <= '0;
                valid_reg  <= '0;
                sum_x_reg  <= '0;
                sum_z_reg  <= '0;
            end
            else if (state_reg == dam_pkg::T_IDLE && accept
                     && in_data.action == dam_pkg::ACT_CLEAR)
            begin
                slot_reg  <= '0;
                valid_reg <= '0;
                sum_x_reg <= '0;
                sum_z_reg <= '0;
            end
            else if (state_reg == dam_pkg::T_UPDATE)
            begin
                sum_x_reg           <= new_x;
                sum_z_reg           <= new_z;
                valid_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_inc == window_reg) ? '0 : SLOT_W'(slot_inc);
            end
            if (state_reg == dam_pkg::T_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dam_pkg::T_UPDATE)
        begin
            sh_x_reg <= new_x;
            sh_z_reg <= new_z;
        end
        else if (state_reg == dam_pkg::T_SHIFT && !fits)
        begin
            sh_x_reg <= sh_x_reg >>> 1;
            sh_z_reg <= sh_z_reg >>> 1;
        end
        if (state_reg == dam_pkg::T_IDLE)
        begin
            res_reg <= '0;
        end
        else if (state_reg == dam_pkg::T_NORM_SUM && norm_done)
        begin
            res_reg <= {nx, nz};
        end
        if (state_reg == dam_pkg::T_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg <= res_reg;
        end
    end

    assign in_ready  = state_reg == dam_pkg::T_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign prdata    = 32'(window_reg);
    assign pready    = 1'b1;

`ifndef ASSERT_OFF
    a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        WIN_W'(slot_reg) < window_reg)
        else $error("write slot outside window");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> (state_reg == dam_pkg::T_NORM_IN || state_reg == dam_pkg::T_NORM_SUM))
        else $error("normalizer done while not waited for");

    a_clear_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.action == dam_pkg::ACT_CLEAR)
        |=> (sum_x_reg == '0 && sum_z_reg == '0 && valid_reg == '0))
        else $error("clear did not zero state");
`endif

endmodule
